### hw/rtl/ebalu_pkg.sv
`default_nettype none

package ebalu_pkg;

  // Operation codes carried in the func field.
  localparam logic [3:0] FUNC_ADD = 4'd0;
  localparam logic [3:0] FUNC_ADC = 4'd1;
  localparam logic [3:0] FUNC_SUB = 4'd2;
  localparam logic [3:0] FUNC_SBB = 4'd3;
  localparam logic [3:0] FUNC_INR = 4'd4;
  localparam logic [3:0] FUNC_DCR = 4'd5;
  localparam logic [3:0] FUNC_INX = 4'd6;
  localparam logic [3:0] FUNC_DCX = 4'd7;
  localparam logic [3:0] FUNC_DAD = 4'd8;
  localparam logic [3:0] FUNC_DAA = 4'd9;

  // Decimal adjust constants.
  localparam logic [3:0] BCD_MAX_DIGIT = 4'd9;
  localparam logic [7:0] DAA_LOW_FIX   = 8'h06;
  localparam logic [7:0] DAA_HIGH_FIX  = 8'h60;

  // One command item.
  typedef struct packed {
    logic [3:0]  func;
    logic [7:0]  acc_in;
    logic [7:0]  operand;
    logic [15:0] pair_in;
    logic [15:0] hl_in;
    logic        carry_in;
    logic        aux_in;
  } ebalu_cmd_t;

  // One result item.
  typedef struct packed {
    logic [7:0]  value8_out;
    logic [15:0] value16_out;
    logic        carry_out;
    logic        sign_out;
    logic        zero_out;
    logic        parity_out;
    logic        aux_out;
    logic        szpa_written;
    logic        carry_written;
  } ebalu_res_t;

endpackage

`default_nettype wire

### hw/rtl/eight_bit_alu_with_status_flags_unit.sv
`default_nettype none

// Eight-bit arithmetic unit with status flags.
//
// Command channel: a transfer happens on each rising edge where start is
// high and busy is low. busy is always low, so a new command may be issued
// in every cycle.
// Result channel: done is high for exactly one cycle with the result on res.
// The receiver cannot hold results off; each result must be taken in the
// cycle it is shown.
// From the command transfer to done, the command is captured in an input
// register, the adders and flag network work on it in the following cycle,
// and the result register drives res and done.
// Throughput is one command per cycle, set by the single 8-bit adder and
// the single 16-bit adder that each command passes through once.
// Synchronous reset clears the valid flags of both registers, so no result
// appears until a command is issued after reset.
module eight_bit_alu_with_status_flags_unit
  import ebalu_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  output logic            busy,
  input  wire ebalu_cmd_t cmd,
  output logic            done,
  output ebalu_res_t      res
);

  logic       stage_valid;
  ebalu_cmd_t stage_cmd;
  ebalu_res_t res_next;

  // The unit never refuses a command.
  assign busy = 1'b0;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else begin
      stage_valid <= start && !busy;
    end
    if (start && !busy) begin
      stage_cmd <= cmd;
    end
  end

  // Operand selection for the shared 8-bit and 16-bit adders.
  logic [7:0]  add_a;
  logic [7:0]  add_b;
  logic        add_cin;
  logic [8:0]  sum8;
  logic [4:0]  sum4;
  logic [15:0] wide_b;
  logic [16:0] sum16;
  logic [3:0]  lo_nib;
  logic [3:0]  hi_nib;
  logic        daa_low;
  logic        daa_high;

  always_comb begin
    lo_nib   = stage_cmd.acc_in[3:0];
    hi_nib   = stage_cmd.acc_in[7:4];
    daa_low  = stage_cmd.aux_in || (lo_nib > BCD_MAX_DIGIT);
    daa_high = stage_cmd.carry_in || (hi_nib > BCD_MAX_DIGIT) ||
               ((hi_nib >= BCD_MAX_DIGIT) && (lo_nib > BCD_MAX_DIGIT));

    add_a   = stage_cmd.acc_in;
    add_b   = stage_cmd.operand;
    add_cin = 1'b0;
    case (stage_cmd.func)
      FUNC_ADD: begin
        add_cin = 1'b0;
      end
      FUNC_ADC: begin
        add_cin = stage_cmd.carry_in;
      end
      FUNC_SUB: begin
        add_b   = ~stage_cmd.operand;
        add_cin = 1'b1;
      end
      FUNC_SBB: begin
        add_b   = ~stage_cmd.operand;
        add_cin = ~stage_cmd.carry_in;
      end
      FUNC_INR: begin
        add_a = stage_cmd.operand;
        add_b = 8'h01;
      end
      FUNC_DCR: begin
        add_a = stage_cmd.operand;
        add_b = 8'hFF;
      end
      FUNC_DAA: begin
        add_b = (daa_low ? DAA_LOW_FIX : 8'h00) | (daa_high ? DAA_HIGH_FIX : 8'h00);
      end
      default: begin
        add_cin = 1'b0;
      end
    endcase

    sum8 = {1'b0, add_a} + {1'b0, add_b} + {8'h00, add_cin};
    sum4 = {1'b0, add_a[3:0]} + {1'b0, add_b[3:0]} + {4'h0, add_cin};

    // Pair increment, pair decrement and HL plus pair share one adder.
    case (stage_cmd.func)
      FUNC_INX: wide_b = 16'h0001;
      FUNC_DCX: wide_b = 16'hFFFF;
      default:  wide_b = stage_cmd.hl_in;
    endcase
    sum16 = {1'b0, stage_cmd.pair_in} + {1'b0, wide_b};
  end

  // Result selection and flag network.
  always_comb begin
    res_next = '0;
    case (stage_cmd.func)
      FUNC_ADD, FUNC_ADC: begin
        res_next.value8_out    = sum8[7:0];
        res_next.carry_out     = sum8[8];
        res_next.aux_out       = sum4[4];
        res_next.szpa_written  = 1'b1;
        res_next.carry_written = 1'b1;
      end
      FUNC_SUB, FUNC_SBB: begin
        res_next.value8_out    = sum8[7:0];
        res_next.carry_out     = ~sum8[8];
        res_next.aux_out       = sum4[4];
        res_next.szpa_written  = 1'b1;
        res_next.carry_written = 1'b1;
      end
      FUNC_INR, FUNC_DCR: begin
        res_next.value8_out   = sum8[7:0];
        res_next.aux_out      = sum4[4];
        res_next.szpa_written = 1'b1;
      end
      FUNC_INX, FUNC_DCX: begin
        res_next.value16_out = sum16[15:0];
      end
      FUNC_DAD: begin
        res_next.value16_out   = sum16[15:0];
        res_next.carry_out     = sum16[16];
        res_next.carry_written = 1'b1;
      end
      FUNC_DAA: begin
        res_next.value8_out    = sum8[7:0];
        res_next.carry_out     = stage_cmd.carry_in || daa_high;
        res_next.aux_out       = sum4[4];
        res_next.szpa_written  = 1'b1;
        res_next.carry_written = 1'b1;
      end
      default: begin
        res_next = '0;
      end
    endcase

    // Sign, zero and parity describe the 8-bit result when they are written.
    if (res_next.szpa_written) begin
      res_next.sign_out   = res_next.value8_out[7];
      res_next.zero_out   = (res_next.value8_out == 8'h00);
      res_next.parity_out = ~^res_next.value8_out;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= stage_valid;
    end
    if (stage_valid) begin
      res <= res_next;
    end
  end

  // Every result strobe has a matching command transfer, passed through the input register and the result register.
  a_done_follows_start: assert property (
    @(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 2)
  ) else $error("result strobe without a matching command");

  // Flags that are not written read as zero.
  a_szpa_clear: assert property (
    @(posedge clk) disable iff (rst)
    (done && !res.szpa_written) |->
      (!res.sign_out && !res.zero_out && !res.parity_out && !res.aux_out)
  ) else $error("unwritten sign, zero, parity or aux flag is set");

  a_carry_clear: assert property (
    @(posedge clk) disable iff (rst)
    (done && !res.carry_written) |-> !res.carry_out
  ) else $error("unwritten carry flag is set");

  // Zero flag agrees with the 8-bit value when flags are written.
  a_zero_matches: assert property (
    @(posedge clk) disable iff (rst)
    (done && res.szpa_written) |-> (res.zero_out == (res.value8_out == 8'h00))
  ) else $error("zero flag disagrees with the 8-bit result");

endmodule

`default_nettype wire
